// File: src/owb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package owb_pkg;

  localparam int TIMER_BITS_DEF = 10;

  localparam int NUM_REGS  = 7;
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

  localparam logic [REG_W-1:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [REG_W-1:0] PRESENCE_WAIT_DEF = 10'd60;
  localparam logic [REG_W-1:0] RESET_TAIL_DEF    = 10'd420;
  localparam logic [REG_W-1:0] SLOT_LOW_DEF      = 10'd1;
  localparam logic [REG_W-1:0] WRITE_HOLD_DEF    = 10'd60;
  localparam logic [REG_W-1:0] READ_SAMPLE_DEF   = 10'd14;
  localparam logic [REG_W-1:0] READ_TAIL_DEF     = 10'd45;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  // item kinds
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_RESET = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_RBYTE = 3'd3;
  localparam logic [2:0] KIND_RBIT  = 3'd4;

  // phase codes
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RST_LOW  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RST_WAIT = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RST_TAIL = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SLOT_LOW = 3'd4;
  localparam logic [PHASE_W-1:0] PH_WR_HOLD  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RD_WAIT  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_RD_TAIL  = 3'd7;

  // running operation
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_RBYTE = 3'd3;
  localparam logic [2:0] OP_RBIT  = 3'd4;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_presence;
    logic       rejected;
  } owb_result_t;

endpackage
`default_nettype wire

// File: src/owb_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module owb_engine
  import owb_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        line_level,
  input  wire cfg_regs_t   regs,
  output owb_result_t      res
);

  localparam int WIDE_W = 17;
  localparam logic [WIDE_W-1:0] MAX_CNT = WIDE_W'((1 << TIMER_BITS) - 1);

  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] tick_count_r, tick_count_nxt;
  logic [3:0]            bits_left_r, bits_left_nxt;
  logic [7:0]            shift_reg_r, shift_reg_nxt;
  logic                  first_sample_r, first_sample_nxt;
  logic [2:0]            operation_r, operation_nxt;

  logic [TIMER_BITS-1:0] cnt_dec;
  logic [3:0]            bits_dec;

  // zero acts as one, too wide clips to the counter's maximum
  function automatic logic [TIMER_BITS-1:0] load_val(input logic [REG_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = {{(WIDE_W-REG_W){1'b0}}, v};
    if (w == '0) w = WIDE_W'(1);
    if (w > MAX_CNT) w = MAX_CNT;
    return w[TIMER_BITS-1:0];
  endfunction

  assign cnt_dec  = (tick_count_r != '0) ? tick_count_r - 1'b1 : tick_count_r;
  assign bits_dec = bits_left_r - 4'd1;

  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    bits_left_nxt    = bits_left_r;
    shift_reg_nxt    = shift_reg_r;
    first_sample_nxt = first_sample_r;
    operation_nxt    = operation_r;
    res              = '0;

    priority if (kind >= KIND_RESET && kind <= KIND_RBIT) begin
      if (phase_r != PH_IDLE) begin
        res.rejected = 1'b1;
      end else if (kind == KIND_RESET) begin
        operation_nxt  = OP_RESET;
        phase_nxt      = PH_RST_LOW;
        tick_count_nxt = load_val(regs[REG_RESET_LOW]);
      end else begin
        operation_nxt  = (kind == KIND_WRITE) ? OP_WRITE :
                         (kind == KIND_RBYTE) ? OP_RBYTE : OP_RBIT;
        bits_left_nxt  = (kind == KIND_RBIT) ? 4'd1 : 4'd8;
        shift_reg_nxt  = (kind == KIND_WRITE) ? data_byte : 8'd0;
        phase_nxt      = PH_SLOT_LOW;
        tick_count_nxt = load_val(regs[REG_SLOT_LOW]);
      end
    end else if (kind == KIND_TICK && phase_r != PH_IDLE) begin
      tick_count_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        unique case (phase_r)
          PH_RST_LOW: begin
            phase_nxt      = PH_RST_WAIT;
            tick_count_nxt = load_val(regs[REG_PRESENCE_WAIT]);
          end
          PH_RST_WAIT: begin
            first_sample_nxt = line_level;
            phase_nxt        = PH_RST_TAIL;
            tick_count_nxt   = load_val(regs[REG_RESET_TAIL]);
          end
          PH_RST_TAIL: begin
            res.no_presence = (line_level == first_sample_r);
            res.done_res    = 1'b1;
            phase_nxt       = PH_IDLE;
            operation_nxt   = OP_NONE;
          end
          PH_SLOT_LOW: begin
            if (operation_r == OP_WRITE) begin
              phase_nxt      = PH_WR_HOLD;
              tick_count_nxt = load_val(regs[REG_WRITE_HOLD]);
            end else begin
              phase_nxt      = PH_RD_WAIT;
              tick_count_nxt = load_val(regs[REG_READ_SAMPLE]);
            end
          end
          PH_WR_HOLD: begin
            shift_reg_nxt = {1'b0, shift_reg_r[7:1]};
            bits_left_nxt = bits_dec;
            if (bits_dec == 4'd0) begin
              res.done_res  = 1'b1;
              phase_nxt     = PH_IDLE;
              operation_nxt = OP_NONE;
            end else begin
              phase_nxt      = PH_SLOT_LOW;
              tick_count_nxt = load_val(regs[REG_SLOT_LOW]);
            end
          end
          PH_RD_WAIT: begin
            shift_reg_nxt  = {line_level, shift_reg_r[7:1]};
            phase_nxt      = PH_RD_TAIL;
            tick_count_nxt = load_val(regs[REG_READ_TAIL]);
          end
          PH_RD_TAIL: begin
            bits_left_nxt = bits_dec;
            if (bits_dec == 4'd0) begin
              res.done_res  = 1'b1;
              res.read_data = (operation_r == OP_RBIT) ? {7'd0, shift_reg_r[7]} : shift_reg_r;
              phase_nxt     = PH_IDLE;
              operation_nxt = OP_NONE;
            end else begin
              phase_nxt      = PH_SLOT_LOW;
              tick_count_nxt = load_val(regs[REG_SLOT_LOW]);
            end
          end
          default: begin
            phase_nxt     = PH_IDLE;
            operation_nxt = OP_NONE;
          end
        endcase
      end
    end else begin
      // idle tick or unknown kind: nothing moves
    end

    res.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_LOW) ||
                    ((phase_nxt == PH_WR_HOLD) && !shift_reg_nxt[0]);
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      tick_count_r   <= '0;
      bits_left_r    <= '0;
      shift_reg_r    <= '0;
      first_sample_r <= 1'b0;
      operation_r    <= OP_NONE;
    end else if (step) begin
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      bits_left_r    <= bits_left_nxt;
      shift_reg_r    <= shift_reg_nxt;
      first_sample_r <= first_sample_nxt;
      operation_r    <= operation_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/one_wire_bus_master_top.sv
`timescale 1ns / 1ps
`default_nettype none
// result: a request's result is in the output register in the cycle after it is taken
// throughput: one request per cycle while the output register is empty or its result is being taken; the output
// register frees up as its result is taken; the bus state update is combinational logic between the state registers
// and the output register; reset (synchronous, rst_n low) returns to idle, empties the output register and
// restores every timing register to its default
module one_wire_bus_master_top
  import owb_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [2:0]           in_kind,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_line_level,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic                 out_drive_low,
  output      logic                 out_busy_res,
  output      logic                 out_done_res,
  output      logic [7:0]           out_read_data,
  output      logic                 out_no_presence,
  output      logic                 out_rejected,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  cfg_regs_t   regs_r;
  owb_result_t res;
  owb_result_t res_r;
  logic        out_valid_r;
  logic        step;

  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_RESET_LOW]     <= RESET_LOW_DEF;
      regs_r[REG_PRESENCE_WAIT] <= PRESENCE_WAIT_DEF;
      regs_r[REG_RESET_TAIL]    <= RESET_TAIL_DEF;
      regs_r[REG_SLOT_LOW]      <= SLOT_LOW_DEF;
      regs_r[REG_WRITE_HOLD]    <= WRITE_HOLD_DEF;
      regs_r[REG_READ_SAMPLE]   <= READ_SAMPLE_DEF;
      regs_r[REG_READ_TAIL]     <= READ_TAIL_DEF;
    end else if (cfg_valid && cfg_ready && (cfg_index <= REG_READ_TAIL)) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  owb_engine #(
    .TIMER_BITS(TIMER_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .kind       (in_kind),
    .data_byte  (in_data_byte),
    .line_level (in_line_level),
    .regs       (regs_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_low   = res_r.drive_low;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_read_data   = res_r.read_data;
  assign out_no_presence = res_r.no_presence;
  assign out_rejected    = res_r.rejected;

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import owb_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASE_ITEMS    = 40;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       line;
  } bus_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_kind = KIND_TICK;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_line_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_drive_low;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [7:0]           out_read_data;
  logic                 out_no_presence;
  logic                 out_rejected;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RESET_LOW;
  logic [REG_W-1:0]     cfg_data = '0;

  one_wire_bus_master_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .in_line_level   (in_line_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_low   (out_drive_low),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_read_data   (out_read_data),
    .out_no_presence (out_no_presence),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the bus master
  logic [PHASE_W-1:0]        bus_phase;
  logic [TIMER_BITS_DEF-1:0] tick_left;
  logic [3:0]                bits_left;
  logic [7:0]                shift_q;
  logic                      first_level;
  logic [2:0]                bus_op;
  logic [REG_W-1:0]          tmr_reg [NUM_REGS];

  const logic [CFG_IDX_W-1:0] reg_order [NUM_REGS] = '{REG_RESET_LOW, REG_PRESENCE_WAIT,
    REG_RESET_TAIL, REG_SLOT_LOW, REG_WRITE_HOLD, REG_READ_SAMPLE, REG_READ_TAIL};

  bus_req_t    req_q [$];
  owb_result_t bus_result_q [$];

  bit in_took = 1'b0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int holdoff_ask = 0;
  int errors = 0;
  int n_req = 0;
  int n_checked = 0;
  int n_done = 0;
  int n_rej = 0;
  int n_nopres = 0;
  int n_settings = 0;

  // a zero register counts as one tick
  function automatic int ticks_for(logic [CFG_IDX_W-1:0] idx);
    return (tmr_reg[idx] == '0) ? 1 : int'(tmr_reg[idx]);
  endfunction

  function automatic logic [TIMER_BITS_DEF-1:0] load_span(logic [CFG_IDX_W-1:0] idx);
    return TIMER_BITS_DEF'(ticks_for(idx));
  endfunction

  task automatic clear_bus_model();
    bus_phase   = PH_IDLE;
    tick_left   = '0;
    bits_left   = '0;
    shift_q     = '0;
    first_level = 1'b0;
    bus_op      = OP_NONE;
    tmr_reg     = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF, SLOT_LOW_DEF,
                    WRITE_HOLD_DEF, READ_SAMPLE_DEF, READ_TAIL_DEF};
  endtask

  function automatic owb_result_t bus_step(logic [2:0] kind, logic [7:0] data, logic line);
    owb_result_t r;
    r = '0;
    if (kind >= KIND_RESET && kind <= KIND_RBIT) begin
      if (bus_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (kind == KIND_RESET) begin
        bus_op    = OP_RESET;
        bus_phase = PH_RST_LOW;
        tick_left = load_span(REG_RESET_LOW);
      end else begin
        bus_op    = (kind == KIND_WRITE) ? OP_WRITE : (kind == KIND_RBYTE) ? OP_RBYTE : OP_RBIT;
        bits_left = (kind == KIND_RBIT) ? 4'd1 : 4'd8;
        shift_q   = (kind == KIND_WRITE) ? data : 8'h00;
        bus_phase = PH_SLOT_LOW;
        tick_left = load_span(REG_SLOT_LOW);
      end
    end else if (kind == KIND_TICK && bus_phase != PH_IDLE) begin
      if (tick_left != '0) tick_left = tick_left - 1'b1;
      if (tick_left == '0) begin
        case (bus_phase)
          PH_RST_LOW: begin
            bus_phase = PH_RST_WAIT;
            tick_left = load_span(REG_PRESENCE_WAIT);
          end
          PH_RST_WAIT: begin
            first_level = line;
            bus_phase   = PH_RST_TAIL;
            tick_left   = load_span(REG_RESET_TAIL);
          end
          PH_RST_TAIL: begin
            r.no_presence = (line == first_level);
            r.done_res    = 1'b1;
            bus_phase     = PH_IDLE;
            bus_op        = OP_NONE;
          end
          PH_SLOT_LOW: begin
            if (bus_op == OP_WRITE) begin
              bus_phase = PH_WR_HOLD;
              tick_left = load_span(REG_WRITE_HOLD);
            end else begin
              bus_phase = PH_RD_WAIT;
              tick_left = load_span(REG_READ_SAMPLE);
            end
          end
          PH_WR_HOLD: begin
            shift_q   = shift_q >> 1;
            bits_left = bits_left - 1'b1;
            if (bits_left == '0) begin
              r.done_res = 1'b1;
              bus_phase  = PH_IDLE;
              bus_op     = OP_NONE;
            end else begin
              bus_phase = PH_SLOT_LOW;
              tick_left = load_span(REG_SLOT_LOW);
            end
          end
          PH_RD_WAIT: begin
            // lsb first: each sampled bit enters at the top
            shift_q   = {line, shift_q[7:1]};
            bus_phase = PH_RD_TAIL;
            tick_left = load_span(REG_READ_TAIL);
          end
          PH_RD_TAIL: begin
            bits_left = bits_left - 1'b1;
            if (bits_left == '0) begin
              r.done_res  = 1'b1;
              r.read_data = (bus_op == OP_RBIT) ? {7'b0, shift_q[7]} : shift_q;
              bus_phase   = PH_IDLE;
              bus_op      = OP_NONE;
            end else begin
              bus_phase = PH_SLOT_LOW;
              tick_left = load_span(REG_SLOT_LOW);
            end
          end
          default: begin
            bus_phase = PH_IDLE;
            bus_op    = OP_NONE;
          end
        endcase
      end
    end
    if (bus_phase == PH_RST_LOW || bus_phase == PH_SLOT_LOW) r.drive_low = 1'b1;
    else if (bus_phase == PH_WR_HOLD) r.drive_low = ~shift_q[0];
    else r.drive_low = 1'b0;
    r.busy_res = (bus_phase != PH_IDLE);
    return r;
  endfunction

  task automatic note_field(string fname, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
    end
  endtask

  // monitor: checks results, tracks accepted requests and register writes
  always @(posedge clk) begin
    owb_result_t want;
    if (!rst_n) begin
      clear_bus_model();
      in_took = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (bus_result_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with nothing expected, expected none, got busy=%0b done=%0b",
                     $time, out_busy_res, out_done_res);
        end else begin
          want = bus_result_q.pop_front();
          n_checked++;
          note_field("drive_low", want.drive_low, out_drive_low);
          note_field("busy_res", want.busy_res, out_busy_res);
          note_field("done_res", want.done_res, out_done_res);
          note_field("read_data", want.read_data, out_read_data);
          note_field("no_presence", want.no_presence, out_no_presence);
          note_field("rejected", want.rejected, out_rejected);
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) begin
        want = bus_step(in_kind, in_data_byte, in_line_level);
        bus_result_q.push_back(want);
        n_req++;
        if (want.done_res) n_done++;
        if (want.rejected) n_rej++;
        if (want.no_presence) n_nopres++;
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) tmr_reg[cfg_index] = cfg_data;
    end
  end

  // driver: feeds the request queue, idling at random between requests
  always @(negedge clk) begin
    bus_req_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (req_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid      <= 1'b1;
        in_kind       <= nxt.kind;
        in_data_byte  <= nxt.data;
        in_line_level <= nxt.line;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  int holdoff_seen = 0;
  int holdoff_left = 0;
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_ask) begin
      holdoff_seen = holdoff_ask;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  task automatic queue_req(logic [2:0] k, logic [7:0] d, logic l);
    req_q.push_back('{kind: k, data: d, line: l});
  endtask

  task automatic queue_tick();
    queue_req(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  function automatic logic [2:0] any_command();
    return KIND_RESET + 3'($urandom_range(0, 3));
  endfunction

  function automatic int op_ticks(logic [2:0] cmd);
    int rd_slot;
    rd_slot = ticks_for(REG_SLOT_LOW) + ticks_for(REG_READ_SAMPLE) + ticks_for(REG_READ_TAIL);
    case (cmd)
      KIND_RESET: return ticks_for(REG_RESET_LOW) + ticks_for(REG_PRESENCE_WAIT) +
                         ticks_for(REG_RESET_TAIL);
      KIND_WRITE: return 8 * (ticks_for(REG_SLOT_LOW) + ticks_for(REG_WRITE_HOLD));
      KIND_RBYTE: return 8 * rd_slot;
      default:    return rd_slot;
    endcase
  endfunction

  // one full operation; an interrupted one gets a stray command mid-way
  task automatic queue_op(logic [2:0] cmd, bit interrupted);
    int total;
    int cut;
    total = op_ticks(cmd);
    cut = interrupted ? $urandom_range(0, total - 1) : -1;
    queue_req(cmd, 8'($urandom), 1'($urandom));
    for (int i = 0; i < total; i++) begin
      if (i == cut) queue_req(any_command(), 8'($urandom), 1'($urandom));
      else if ($urandom_range(0, 24) == 0)
        queue_req(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), 8'($urandom),
                  1'($urandom));
      queue_tick();
    end
  endtask

  task automatic gen_traffic(int budget);
    int made;
    int pick;
    logic [2:0] cmd;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        cmd = any_command();
        queue_op(cmd, pick < 15);
        made += op_ticks(cmd) + 1;
      end else begin
        // idle ticks and unknown kinds between operations
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0)
            queue_req(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), 8'($urandom),
                      1'($urandom));
          else
            queue_tick();
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (req_q.size() != 0 || in_valid || bus_result_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // finish any operation still running so the registers change only while idle
  task automatic settle();
    wait_drained();
    while (bus_phase != PH_IDLE) begin
      repeat (32) queue_tick();
      wait_drained();
    end
  endtask

  task automatic set_timing(int lo, int hi, int zero_pct);
    int v;
    for (int i = 0; i < NUM_REGS; i++) begin
      v = ($urandom_range(0, 99) < zero_pct) ? 0 : $urandom_range(lo, hi);
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= REG_W'(v);
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int snd, int rcv, int hi, bit hold);
    set_timing(1, hi, 12);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    gen_traffic(PHASE_ITEMS);
    if (hold) holdoff_ask++;
    settle();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all registers zero: every phase lasts one tick
    set_timing(0, 0, 0);
    queue_req(KIND_TICK, 8'h00, 1'b1);
    for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++) queue_req(3'(k), 8'hFF, 1'b1);
    // presence seen: samples differ
    queue_req(KIND_RESET, 8'hFF, 1'b0);
    queue_req(KIND_RBIT, 8'h00, 1'b1);
    queue_req(KIND_TICK, 8'h00, 1'b1);
    queue_req(KIND_TICK, 8'h00, 1'b0);
    queue_req(KIND_TICK, 8'h00, 1'b1);
    // no presence: samples equal
    queue_req(KIND_RESET, 8'h00, 1'b1);
    queue_req(KIND_TICK, 8'hFF, 1'b0);
    queue_req(KIND_TICK, 8'hFF, 1'b1);
    queue_req(KIND_UNUSED_HI, 8'hFF, 1'b0);
    queue_req(KIND_TICK, 8'hFF, 1'b1);
    queue_req(KIND_RBIT, 8'hFF, 1'b0);
    queue_req(KIND_TICK, 8'h00, 1'b0);
    queue_req(KIND_TICK, 8'h00, 1'b1);
    queue_req(KIND_TICK, 8'h00, 1'b0);
    queue_req(KIND_WRITE, 8'hFF, 1'b0);
    queue_req(KIND_WRITE, 8'h00, 1'b1);
    repeat (16) queue_req(KIND_TICK, 8'h00, 1'b0);
    queue_req(KIND_RBYTE, 8'h00, 1'b0);
    for (int b = 0; b < 24; b++) queue_req(KIND_TICK, 8'hFF, 1'(b / 3));
    settle();

    run_phase(0, 0, 3, 1'b0);
    run_phase(56, 0, 4, 1'b0);
    run_phase(0, 56, 3, 1'b1);
    run_phase(34, 34, 6, 1'b0);

    // longest count on the reset pulse, short counts elsewhere
    set_timing(1, 2, 0);
    set_reg(REG_RESET_LOW, REG_W'(1023));
    snd_idle_pct  = 34;
    rcv_stall_pct = 34;
    queue_op(KIND_RESET, 1'b1);
    queue_op(KIND_RBIT, 1'b1);
    settle();

    run_phase(34, 34, 2, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("exercised %0d requests, %0d results checked, over %0d timing settings",
             n_req, n_checked, n_settings);
    $display("%0d operations completed, %0d commands turned away, %0d resets without presence",
             n_done, n_rej, n_nopres);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout with %0d requests waiting and %0d results due", req_q.size(),
             bus_result_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
